// File: hdl/itve_pkg.sv
// Shared types and character constants for the IRC tag value extractor.
package itve_pkg;

  // One byte of the tag string.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_t;

  // One result item.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       which_field;
    logic       value_done;
    logic       tags_done;
    logic       last_result;
  } out_t;

  // Configuration register indexes.
  localparam logic CFG_WANT_LOGIN      = 1'b0;
  localparam logic CFG_WANT_SYSTEM_MSG = 1'b1;

  // Field codes.
  localparam logic FIELD_LOGIN  = 1'b0;
  localparam logic FIELD_SYSMSG = 1'b1;

  // Characters of interest.
  localparam logic [7:0] CH_EQUAL     = 8'h3D;  // '='
  localparam logic [7:0] CH_SEMI      = 8'h3B;  // ';'
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_S         = 8'h73;  // 's'
  localparam logic [7:0] CH_COLON     = 8'h3A;  // ':'
  localparam logic [7:0] CH_R         = 8'h72;  // 'r'
  localparam logic [7:0] CH_N         = 8'h6E;  // 'n'
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;

  localparam logic [3:0] LOGIN_LEN  = 4'd5;
  localparam logic [3:0] SYSMSG_LEN = 4'd10;
  localparam logic [3:0] KEY_POS_MAX = 4'd15;

  // Expected byte of "login" at a key position.
  function automatic logic [7:0] login_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h6C;  // l
      4'd1:    ch = 8'h6F;  // o
      4'd2:    ch = 8'h67;  // g
      4'd3:    ch = 8'h69;  // i
      4'd4:    ch = 8'h6E;  // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Expected byte of "system-msg" at a key position.
  function automatic logic [7:0] sysmsg_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h73;  // s
      4'd1:    ch = 8'h79;  // y
      4'd2:    ch = 8'h73;  // s
      4'd3:    ch = 8'h74;  // t
      4'd4:    ch = 8'h65;  // e
      4'd5:    ch = 8'h6D;  // m
      4'd6:    ch = 8'h2D;  // -
      4'd7:    ch = 8'h6D;  // m
      4'd8:    ch = 8'h73;  // s
      4'd9:    ch = 8'h67;  // g
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Map the byte after a backslash to its decoded value.
  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] d;
    case (c)
      CH_S:     d = CH_SPACE;
      CH_COLON: d = CH_SEMI;
      CH_R:     d = CH_CR;
      CH_N:     d = CH_LF;
      default:  d = c;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/irc_tag_value_extractor.sv
// Top level of the IRC tag value extractor: key matcher, unescaper, result register.
// A result is in the output register in the cycle after its input transfer.
// Throughput: one byte per cycle, set by the tag state loop; a byte is
// held only while a result waits under stall, and enters as that result transfers.
// Reset (rst, synchronous, active high): tag state to key phase, output empty,
// want_login and want_system_msg set.
module irc_tag_value_extractor (
  input  logic            clk,
  input  logic            rst,
  // byte input
  input  logic            in_valid,
  output logic            in_stall,
  input  itve_pkg::in_t   in_data,
  // result output
  output logic            out_valid,
  input  logic            out_stall,
  output itve_pkg::out_t  out_data,
  // configuration writes
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [0:0]      cfg_wdata
);

  // Phase codes of the tag parser.
  localparam logic [1:0] PH_KEY   = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_SKIP  = 2'd2;

  // Configuration registers.
  logic want_login;
  logic want_system_msg;

  // Tag parser state.
  logic [1:0] phase,       phase_next;
  logic [3:0] key_pos,     key_pos_next;
  logic       login_match, login_match_next;
  logic       sys_match,   sys_match_next;
  logic       esc_pending, esc_pending_next;
  logic       act_field,   act_field_next;

  // Result of the byte at the input.
  logic           emit;
  itve_pkg::out_t res;

  logic       in_fire;
  logic [7:0] c;
  logic       last;
  logic       is_login;
  logic       is_sys;

  // Hold the input only when a finished result is waiting and the consumer stalls.
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign c        = in_data.in_byte;
  assign last     = in_data.is_last;

  assign is_login = login_match && (key_pos == itve_pkg::LOGIN_LEN);
  assign is_sys   = sys_match && (key_pos == itve_pkg::SYSMSG_LEN);

  // Per-byte parse step: next tag state and the result, if any.
  always_comb begin
    phase_next       = phase;
    key_pos_next     = key_pos;
    login_match_next = login_match;
    sys_match_next   = sys_match;
    esc_pending_next = esc_pending;
    act_field_next   = act_field;
    emit             = 1'b0;
    res              = '0;

    case (phase)
      PH_KEY: begin
        if (c == itve_pkg::CH_EQUAL) begin
          // Registers are sampled here, at the key's '='.
          esc_pending_next = 1'b0;
          if (is_login && want_login) begin
            phase_next     = PH_VALUE;
            act_field_next = itve_pkg::FIELD_LOGIN;
          end else if (is_sys && want_system_msg) begin
            phase_next     = PH_VALUE;
            act_field_next = itve_pkg::FIELD_SYSMSG;
          end else begin
            phase_next = PH_SKIP;
          end
          // A wanted key whose '=' ends the string closes an empty value.
          if (phase_next == PH_VALUE && last) begin
            emit            = 1'b1;
            res.value_done  = 1'b1;
            res.which_field = act_field_next;
          end
        end else if (c == itve_pkg::CH_SEMI) begin
          // Key without '=': drop the tag.
          phase_next       = PH_KEY;
          key_pos_next     = '0;
          login_match_next = 1'b1;
          sys_match_next   = 1'b1;
          esc_pending_next = 1'b0;
          act_field_next   = 1'b0;
        end else begin
          if (key_pos >= itve_pkg::LOGIN_LEN || itve_pkg::login_char(key_pos) != c) begin
            login_match_next = 1'b0;
          end
          if (key_pos >= itve_pkg::SYSMSG_LEN || itve_pkg::sysmsg_char(key_pos) != c) begin
            sys_match_next = 1'b0;
          end
          if (key_pos < itve_pkg::KEY_POS_MAX) begin
            key_pos_next = key_pos + 4'd1;
          end
        end
      end

      PH_VALUE: begin
        res.which_field = act_field;
        if (c == itve_pkg::CH_SEMI) begin
          // ';' always closes the value; a dangling backslash goes out literally.
          emit           = 1'b1;
          res.value_done = 1'b1;
          if (esc_pending) begin
            res.has_byte  = 1'b1;
            res.data_byte = itve_pkg::CH_BACKSLASH;
          end
          phase_next       = PH_KEY;
          key_pos_next     = '0;
          login_match_next = 1'b1;
          sys_match_next   = 1'b1;
          esc_pending_next = 1'b0;
          act_field_next   = 1'b0;
        end else if (act_field == itve_pkg::FIELD_LOGIN) begin
          // Login bytes pass through raw.
          emit          = 1'b1;
          res.has_byte  = 1'b1;
          res.data_byte = c;
        end else if (esc_pending) begin
          emit             = 1'b1;
          res.has_byte     = 1'b1;
          res.data_byte    = itve_pkg::unescape(c);
          esc_pending_next = 1'b0;
        end else if (c == itve_pkg::CH_BACKSLASH && !last) begin
          esc_pending_next = 1'b1;
        end else begin
          emit          = 1'b1;
          res.has_byte  = 1'b1;
          res.data_byte = c;
        end
        if (last) begin
          emit           = 1'b1;
          res.value_done = 1'b1;
          if (esc_pending_next && !res.has_byte) begin
            res.has_byte  = 1'b1;
            res.data_byte = itve_pkg::CH_BACKSLASH;
          end
        end
      end

      default: begin
        // Skip the value of an unwanted key until ';'.
        if (c == itve_pkg::CH_SEMI) begin
          phase_next       = PH_KEY;
          key_pos_next     = '0;
          login_match_next = 1'b1;
          sys_match_next   = 1'b1;
          esc_pending_next = 1'b0;
          act_field_next   = 1'b0;
        end
      end
    endcase

    // End of the tag string: always one result, and a fresh start.
    if (last) begin
      emit             = 1'b1;
      res.tags_done    = 1'b1;
      phase_next       = PH_KEY;
      key_pos_next     = '0;
      login_match_next = 1'b1;
      sys_match_next   = 1'b1;
      esc_pending_next = 1'b0;
      act_field_next   = 1'b0;
    end
    res.last_result = 1'b1;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      want_login      <= 1'b1;
      want_system_msg <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        itve_pkg::CFG_WANT_LOGIN:      want_login      <= cfg_wdata[0];
        itve_pkg::CFG_WANT_SYSTEM_MSG: want_system_msg <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Tag state: advance on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_KEY;
      key_pos     <= '0;
      login_match <= 1'b1;
      sys_match   <= 1'b1;
      esc_pending <= 1'b0;
      act_field   <= 1'b0;
    end else if (in_fire) begin
      phase       <= phase_next;
      key_pos     <= key_pos_next;
      login_match <= login_match_next;
      sys_match   <= sys_match_next;
      esc_pending <= esc_pending_next;
      act_field   <= act_field_next;
    end
  end

  // Output register: load a new result, else drop the one just transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data <= res;
    end
  end

  // A byte that ends the string returns the parser to a clean key phase.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.is_last |=> phase == PH_KEY && key_pos == 4'd0 && !esc_pending)
    else $error("tag state not cleared after final byte");

  // A result without a byte carries a zero byte.
  a_empty_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_byte |-> out_data.data_byte == 8'h00)
    else $error("data_byte nonzero without has_byte");

  // An escape is only ever pending inside a system-msg value.
  a_esc_sysmsg: assert property (@(posedge clk) disable iff (rst)
    esc_pending |-> phase == PH_VALUE && act_field == itve_pkg::FIELD_SYSMSG)
    else $error("escape pending outside system-msg value");

  // A held result is not overwritten while the consumer stalls.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
